>>> hw/rtl/bdp_pkg.sv
`default_nettype none

package bdp_pkg;

    // default sizes for the top level parameters
    localparam int DEF_HISTORY_BITS     = 10;
    localparam int DEF_LOCAL_INDEX_BITS = 10;

    // fixed field widths
    localparam int PC_W       = 32;
    localparam int MODE_W     = 3;
    localparam int CTR_W      = 2;
    localparam int IDX_OUT_W  = 10;
    localparam int HIST_OUT_W = 10;

    // local word: one-bit entry on top, two-bit counter below
    localparam int LWORD_W    = 3;
    localparam int LW_ONE_BIT = 2;

    localparam logic [CTR_W-1:0]   CTR_MIN          = 2'd0;
    localparam logic [CTR_W-1:0]   CTR_MAX          = 2'd3;
    localparam logic [CTR_W-1:0]   CTR_RESET        = 2'd1;
    localparam logic [CTR_W-1:0]   CTR_TAKEN_THRESH = 2'd2;
    localparam logic [LWORD_W-1:0] LWORD_RESET      = {1'b0, CTR_RESET};

    localparam logic OP_PREDICT = 1'b0;
    localparam logic OP_UPDATE  = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_NOT_TAKEN = 3'd0,
        MODE_TAKEN     = 3'd1,
        MODE_ONE_BIT   = 3'd2,
        MODE_TWO_BIT   = 3'd3,
        MODE_GSHARE    = 3'd4
    } t_mode;

    localparam logic [MODE_W-1:0] MODE_RESET = MODE_TWO_BIT;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic            op;
        logic [PC_W-1:0] pc;
        logic            taken;
    } t_bdp_in;

    typedef struct packed {
        logic                  prediction;
        logic [CTR_W-1:0]      counter_state;
        logic                  state_valid;
        logic [IDX_OUT_W-1:0]  table_index;
        logic [HIST_OUT_W-1:0] history_out;
    } t_bdp_out;

    // write strobes raised by the update logic
    typedef struct packed {
        logic local_we;
        logic shared_we;
        logic hist_we;
    } t_upd_ctl;

endpackage

`default_nettype wire

>>> hw/rtl/bdp_ram.sv
`default_nettype none

module bdp_ram #(
    parameter int WIDTH     = 2,
    parameter int ADDR_BITS = 10
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [ADDR_BITS-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]     i_wdata,
    input  wire logic                 i_re,
    input  wire logic [ADDR_BITS-1:0] i_raddr,
    output logic      [WIDTH-1:0]     o_rdata
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hw/rtl/bdp_update.sv
`default_nettype none

module bdp_update
    import bdp_pkg::*;
#(
    parameter int HISTORY_BITS     = DEF_HISTORY_BITS,
    parameter int LOCAL_INDEX_BITS = DEF_LOCAL_INDEX_BITS
) (
    input  wire logic [MODE_W-1:0]           i_mode,
    input  wire t_bdp_in                     i_item,
    input  wire logic [LOCAL_INDEX_BITS-1:0] i_lidx,
    input  wire logic [HISTORY_BITS-1:0]     i_gidx,
    input  wire logic [LWORD_W-1:0]          i_lword,
    input  wire logic [CTR_W-1:0]            i_gword,
    input  wire logic [HISTORY_BITS-1:0]     i_hist,
    output t_bdp_out                         o_res,
    output t_upd_ctl                         o_ctl,
    output logic      [LWORD_W-1:0]          o_lwdata,
    output logic      [CTR_W-1:0]            o_gwdata,
    output logic      [HISTORY_BITS-1:0]     o_hist_next
);

    function automatic logic [CTR_W-1:0] f_bump(input logic [CTR_W-1:0] ctr, input logic tk);
        logic [CTR_W-1:0] res;
        res = ctr;
        if (tk) begin
            if (ctr != CTR_MAX) res = ctr + CTR_W'(1);
        end else begin
            if (ctr != CTR_MIN) res = ctr - CTR_W'(1);
        end
        return res;
    endfunction

    logic                    upd;
    logic [HISTORY_BITS:0]   hist_shift;
    logic [HISTORY_BITS-1:0] hist_after;
    logic [31:0]             idx_ext;
    logic [31:0]             hist_ext;
    logic                    pred;
    logic [CTR_W-1:0]        st;
    logic                    st_valid;

    assign upd        = (i_item.op == OP_UPDATE);
    assign hist_shift = {i_hist, i_item.taken};

    always_comb begin
        pred        = 1'b0;
        st          = CTR_MIN;
        st_valid    = 1'b0;
        idx_ext     = '0;
        o_ctl       = '0;
        o_lwdata    = i_lword;
        o_gwdata    = i_gword;
        o_hist_next = hist_shift[HISTORY_BITS-1:0];
        case (i_mode)
            MODE_TAKEN: begin
                pred = 1'b1;
            end
            MODE_ONE_BIT: begin
                st                   = {1'b0, i_lword[LW_ONE_BIT]};
                pred                 = i_lword[LW_ONE_BIT];
                st_valid             = 1'b1;
                idx_ext              = 32'(i_lidx);
                o_ctl.local_we       = upd;
                o_lwdata[LW_ONE_BIT] = i_item.taken;
            end
            MODE_TWO_BIT: begin
                st                  = i_lword[CTR_W-1:0];
                pred                = (st >= CTR_TAKEN_THRESH);
                st_valid            = 1'b1;
                idx_ext             = 32'(i_lidx);
                o_ctl.local_we      = upd;
                o_lwdata[CTR_W-1:0] = f_bump(i_lword[CTR_W-1:0], i_item.taken);
            end
            MODE_GSHARE: begin
                st              = i_gword;
                pred            = (st >= CTR_TAKEN_THRESH);
                st_valid        = 1'b1;
                idx_ext         = 32'(i_gidx);
                o_ctl.shared_we = upd;
                o_ctl.hist_we   = upd;
                o_gwdata        = f_bump(i_gword, i_item.taken);
            end
            default: begin
                pred = 1'b0;
            end
        endcase
    end

    assign hist_after = o_ctl.hist_we ? o_hist_next : i_hist;
    assign hist_ext   = 32'(hist_after);

    always_comb begin
        o_res.prediction    = pred;
        o_res.counter_state = st;
        o_res.state_valid   = st_valid;
        o_res.table_index   = idx_ext[IDX_OUT_W-1:0];
        o_res.history_out   = hist_ext[HIST_OUT_W-1:0];
    end

endmodule

`default_nettype wire

>>> hw/rtl/branch_direction_predictor_unit.sv
`default_nettype none

// branch direction predictor with five modes selected by the mode register:
// always not taken, always taken, one-bit last outcome, two-bit saturating
// counter, or gshare (shared counters indexed by pc xor global history, history
// shifted on every gshare update). each input beat is a predict or an update for
// one pc and yields one result beat with the prediction, the looked-up state and
// the index as seen before the update, plus the history after it. one item is
// taken per cycle when the output side keeps up; an accepted beat moves to the
// lookup register and its result to the output register; the lookup is fed by
// the registered read of the local and shared tables, each with one read and
// one write port, with a forwarding register covering an update followed at
// once by a read of the same entry. after reset a clearing pass over all
// 2^max(LOCAL_INDEX_BITS, HISTORY_BITS) addresses (1024 at the default sizes)
// walks both tables with input ready held low; the mode register can be written
// at any time the block is idle, reset value two-bit, codes five to seven act as
// always not taken.

module branch_direction_predictor_unit
    import bdp_pkg::*;
#(
    parameter int HISTORY_BITS     = DEF_HISTORY_BITS,
    parameter int LOCAL_INDEX_BITS = DEF_LOCAL_INDEX_BITS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // item channel
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire t_bdp_in           i_in_data,
    // result channel
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_bdp_out               o_out_data,
    // mode register write
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [MODE_W-1:0] i_cfg_data
);

    localparam int CLR_BITS = (LOCAL_INDEX_BITS > HISTORY_BITS) ? LOCAL_INDEX_BITS
                                                                : HISTORY_BITS;

    // control
    t_state                  r_state, n_state;
    logic [CLR_BITS-1:0]     r_clr_addr;
    logic                    clearing;
    logic                    running;
    logic [MODE_W-1:0]       r_mode;

    // lookup stage
    logic                        r_s1_valid;
    t_bdp_in                     r_s1_item;
    logic [LOCAL_INDEX_BITS-1:0] r_s1_lidx;
    logic [HISTORY_BITS-1:0]     r_s1_gidx;
    logic                        s1_adv;
    logic                        in_accept;

    // forwarding of a write to the entry read in the same cycle
    logic                    r_fwd_l_en;
    logic [LWORD_W-1:0]      r_fwd_l_data;
    logic                    r_fwd_g_en;
    logic [CTR_W-1:0]        r_fwd_g_data;

    // history and output register
    logic [HISTORY_BITS-1:0] r_hist;
    logic [HISTORY_BITS-1:0] hist_now;
    logic                    r_out_valid;
    t_bdp_out                r_out;

    // table ports
    logic [LOCAL_INDEX_BITS-1:0] new_lidx;
    logic [HISTORY_BITS-1:0]     new_gidx;
    logic                        l_we;
    logic [LOCAL_INDEX_BITS-1:0] l_waddr;
    logic [LWORD_W-1:0]          l_wdata;
    logic [LWORD_W-1:0]          l_rdata;
    logic                        g_we;
    logic [HISTORY_BITS-1:0]     g_waddr;
    logic [CTR_W-1:0]            g_wdata;
    logic [CTR_W-1:0]            g_rdata;
    logic [LWORD_W-1:0]          l_word;
    logic [CTR_W-1:0]            g_word;

    // update logic outputs
    t_bdp_out                upd_res;
    t_upd_ctl                upd_ctl;
    logic [LWORD_W-1:0]      upd_lwdata;
    logic [CTR_W-1:0]        upd_gwdata;
    logic [HISTORY_BITS-1:0] upd_hist_next;

    // ---------------------------------------------------------------- fsm
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == {CLR_BITS{1'b1}}) n_state = ST_RUN;
            end
            ST_RUN: begin
                n_state = ST_RUN;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        clearing = 1'b0;
        running  = 1'b0;
        case (r_state)
            ST_CLEAR: clearing = 1'b1;
            ST_RUN:   running  = 1'b1;
            default:  clearing = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (clearing) r_clr_addr <= r_clr_addr + CLR_BITS'(1);
        end
    end

    // mode register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_RESET;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_data;
        end
    end

    // ---------------------------------------------------------------- handshakes
    // the lookup stage moves on whenever the output register is free or emptying
    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = running && (!r_s1_valid || s1_adv);
    assign in_accept  = i_in_valid && o_in_ready;

    // history seen by the incoming beat includes the update retiring this cycle
    assign hist_now = (s1_adv && upd_ctl.hist_we) ? upd_hist_next : r_hist;
    assign new_lidx = i_in_data.pc[LOCAL_INDEX_BITS-1:0];
    assign new_gidx = i_in_data.pc[HISTORY_BITS-1:0] ^ hist_now;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd_l_en <= 1'b0;
            r_fwd_g_en <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
                // same entry written as it is read: take the write data
                r_fwd_l_en <= s1_adv && upd_ctl.local_we && (r_s1_lidx == new_lidx);
                r_fwd_g_en <= s1_adv && upd_ctl.shared_we && (r_s1_gidx == new_gidx);
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_item    <= i_in_data;
            r_s1_lidx    <= new_lidx;
            r_s1_gidx    <= new_gidx;
            r_fwd_l_data <= upd_lwdata;
            r_fwd_g_data <= upd_gwdata;
        end
    end

    // ---------------------------------------------------------------- tables
    // clearing pass owns the write ports until it ends
    assign l_we    = clearing || (s1_adv && upd_ctl.local_we);
    assign l_waddr = clearing ? r_clr_addr[LOCAL_INDEX_BITS-1:0] : r_s1_lidx;
    assign l_wdata = clearing ? LWORD_RESET : upd_lwdata;
    assign g_we    = clearing || (s1_adv && upd_ctl.shared_we);
    assign g_waddr = clearing ? r_clr_addr[HISTORY_BITS-1:0] : r_s1_gidx;
    assign g_wdata = clearing ? CTR_RESET : upd_gwdata;

    // one-bit entry and local counter share a word
    bdp_ram #(
        .WIDTH     (LWORD_W),
        .ADDR_BITS (LOCAL_INDEX_BITS)
    ) u_local_ram (
        .i_clk   (i_clk),
        .i_we    (l_we),
        .i_waddr (l_waddr),
        .i_wdata (l_wdata),
        .i_re    (in_accept),
        .i_raddr (new_lidx),
        .o_rdata (l_rdata)
    );

    // gshare counters
    bdp_ram #(
        .WIDTH     (CTR_W),
        .ADDR_BITS (HISTORY_BITS)
    ) u_shared_ram (
        .i_clk   (i_clk),
        .i_we    (g_we),
        .i_waddr (g_waddr),
        .i_wdata (g_wdata),
        .i_re    (in_accept),
        .i_raddr (new_gidx),
        .o_rdata (g_rdata)
    );

    assign l_word = r_fwd_l_en ? r_fwd_l_data : l_rdata;
    assign g_word = r_fwd_g_en ? r_fwd_g_data : g_rdata;

    // ---------------------------------------------------------------- update
    bdp_update #(
        .HISTORY_BITS     (HISTORY_BITS),
        .LOCAL_INDEX_BITS (LOCAL_INDEX_BITS)
    ) u_update (
        .i_mode      (r_mode),
        .i_item      (r_s1_item),
        .i_lidx      (r_s1_lidx),
        .i_gidx      (r_s1_gidx),
        .i_lword     (l_word),
        .i_gword     (g_word),
        .i_hist      (r_hist),
        .o_res       (upd_res),
        .o_ctl       (upd_ctl),
        .o_lwdata    (upd_lwdata),
        .o_gwdata    (upd_gwdata),
        .o_hist_next (upd_hist_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_adv && upd_ctl.hist_we) r_hist <= upd_hist_next;
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) r_out <= upd_res;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---------------------------------------------------------------- checks
    // no beat in flight while the tables are being cleared
    a_no_item_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (r_state == ST_RUN))
        else $error("lookup stage busy during clearing pass");

    // a stalled lookup keeps its indices, the table read data is not reissued
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> (r_s1_valid && $stable(r_s1_lidx)
                                     && $stable(r_s1_gidx)))
        else $error("stalled lookup lost its indices");

    // forwarding only follows a local write that retired on the accept cycle
    a_fwd_local: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_fwd_l_en) |-> $past(s1_adv && upd_ctl.local_we))
        else $error("local forwarding without a matching write");

    a_fwd_shared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_fwd_g_en) |-> $past(s1_adv && upd_ctl.shared_we))
        else $error("shared forwarding without a matching write");

endmodule

`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import bdp_pkg::*;

    // sizes follow the default top level parameters
    localparam int LOCAL_BITS   = DEF_LOCAL_INDEX_BITS;
    localparam int HIST_BITS    = DEF_HISTORY_BITS;
    localparam int LOCAL_DEPTH  = 1 << LOCAL_BITS;
    localparam int SHARED_DEPTH = 1 << HIST_BITS;

    // mode codes past gshare, all behave as always not taken
    localparam logic [MODE_W-1:0] MODE_SPARE_LO  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_MID = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI  = 3'd7;

    // loose limit, well above the clearing pass and the longest idle gap
    localparam int WATCHDOG_LIMIT = 6000;
    // extra wait after the result queue has drained
    localparam int SETTLE_CYCLES  = 6;
    localparam int RANDOM_PHASES  = 9;
    localparam int PHASE_ITEMS    = 120;
    localparam int HOT_PCS        = 8;
    localparam int REPORT_MAX     = 10;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    t_bdp_in             i_in_data;
    logic                o_out_valid;
    logic                i_out_ready;
    t_bdp_out            o_out_data;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [MODE_W-1:0]   i_cfg_data;

    branch_direction_predictor_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // shadow copy of the predictor state
    logic [MODE_W-1:0]    mode_reg;
    logic                 one_bit_tbl   [LOCAL_DEPTH];
    logic [CTR_W-1:0]     local_ctr_tbl [LOCAL_DEPTH];
    logic [CTR_W-1:0]     shared_ctr_tbl[SHARED_DEPTH];
    logic [HIST_BITS-1:0] ghist;

    // predicted result beats, oldest first
    t_bdp_out expected_results[$];
    t_bdp_out want;

    logic [PC_W-1:0] hot_pc [HOT_PCS];

    // when set neither side idles, so beats go back to back
    logic no_stall;

    int beats_sent;
    int updates_sent;
    int mode_writes;
    int results_checked;
    int mismatch_count;
    int stray_count;
    int idle_cycles;

    // free running clock, 2 ns period
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // mostly no gap, sometimes a short one, now and then a long one
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CTR_W-1:0] saturate_step(logic [CTR_W-1:0] ctr, logic tk);
        if (tk) return (ctr < CTR_MAX) ? ctr + 2'd1 : ctr;
        return (ctr > CTR_MIN) ? ctr - 2'd1 : ctr;
    endfunction

    task automatic clear_shadow();
        int i;
        mode_reg = MODE_RESET;
        for (i = 0; i < LOCAL_DEPTH; i++) begin
            one_bit_tbl[i]   = 1'b0;
            local_ctr_tbl[i] = CTR_RESET;
        end
        for (i = 0; i < SHARED_DEPTH; i++) shared_ctr_tbl[i] = CTR_RESET;
        ghist = '0;
    endtask

    // lookup before training, history reported after
    function automatic t_bdp_out predict_and_train(t_bdp_in item);
        t_bdp_out              r;
        logic [LOCAL_BITS-1:0] lidx;
        logic [HIST_BITS-1:0]  sidx;
        logic [CTR_W-1:0]      st;
        r    = '0;
        lidx = item.pc[LOCAL_BITS-1:0];
        sidx = item.pc[HIST_BITS-1:0] ^ ghist;
        case (mode_reg)
            MODE_TAKEN: begin
                r.prediction = 1'b1;
            end
            MODE_ONE_BIT: begin
                st                = {1'b0, one_bit_tbl[lidx]};
                r.prediction      = st[0];
                r.counter_state   = st;
                r.state_valid     = 1'b1;
                r.table_index     = IDX_OUT_W'(lidx);
                if (item.op == OP_UPDATE) one_bit_tbl[lidx] = item.taken;
            end
            MODE_TWO_BIT: begin
                st                = local_ctr_tbl[lidx];
                r.prediction      = (st >= CTR_TAKEN_THRESH);
                r.counter_state   = st;
                r.state_valid     = 1'b1;
                r.table_index     = IDX_OUT_W'(lidx);
                if (item.op == OP_UPDATE) local_ctr_tbl[lidx] = saturate_step(st, item.taken);
            end
            MODE_GSHARE: begin
                st                = shared_ctr_tbl[sidx];
                r.prediction      = (st >= CTR_TAKEN_THRESH);
                r.counter_state   = st;
                r.state_valid     = 1'b1;
                r.table_index     = IDX_OUT_W'(sidx);
                if (item.op == OP_UPDATE) begin
                    shared_ctr_tbl[sidx] = saturate_step(st, item.taken);
                    ghist                = {ghist[HIST_BITS-2:0], item.taken};
                end
            end
            default: begin
                // not taken and the spare codes: no state, nothing learned
            end
        endcase
        r.history_out = HIST_OUT_W'(ghist);
        return r;
    endfunction

    function automatic t_bdp_in make_item(logic op, logic [PC_W-1:0] pc, logic tk);
        t_bdp_in it;
        it.op    = op;
        it.pc    = pc;
        it.taken = tk;
        return it;
    endfunction

    // drive one item beat, called and returning at a falling edge
    task automatic send_branch(t_bdp_in item);
        int gap;
        i_in_data  = item;
        i_in_valid = 1'b1;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        // beat taken at this edge, predict now
        expected_results.push_back(predict_and_train(item));
        beats_sent++;
        if (item.op == OP_UPDATE) updates_sent++;
        @(negedge i_clk);
        gap = no_stall ? 0 : idle_length();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // mode writes only once every result has drained
    task automatic write_mode(logic [MODE_W-1:0] value);
        i_in_valid = 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_data  = value;
        i_cfg_valid = 1'b1;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        mode_reg = value;
        mode_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // reset value of the mode register is two-bit, counters start weakly not taken
    task automatic test_reset_state();
        send_branch(make_item(OP_PREDICT, 32'h0000_0000, 1'b0));
        send_branch(make_item(OP_PREDICT, 32'hFFFF_FFFF, 1'b1));
        send_branch(make_item(OP_UPDATE,  32'h0000_0000, 1'b1));
    endtask

    // fixed directions, spare codes act as not taken, history untouched
    task automatic test_static_modes();
        write_mode(MODE_NOT_TAKEN);
        send_branch(make_item(OP_UPDATE,  32'hFFFF_FFFF, 1'b1));
        send_branch(make_item(OP_PREDICT, 32'h0000_0000, 1'b1));
        write_mode(MODE_TAKEN);
        send_branch(make_item(OP_UPDATE,  32'h0000_0000, 1'b0));
        send_branch(make_item(OP_PREDICT, 32'hFFFF_FFFF, 1'b0));
        write_mode(MODE_SPARE_LO);
        send_branch(make_item(OP_UPDATE,  32'h0000_0040, 1'b1));
        write_mode(MODE_SPARE_MID);
        send_branch(make_item(OP_UPDATE,  32'h0000_0040, 1'b1));
        write_mode(MODE_SPARE_HI);
        send_branch(make_item(OP_UPDATE,  32'hFFFF_FFFF, 1'b1));
    endtask

    // last outcome kept, an alias sharing the low bits sees it
    task automatic test_one_bit();
        write_mode(MODE_ONE_BIT);
        no_stall = 1'b1;
        send_branch(make_item(OP_PREDICT, 32'h0000_03FF, 1'b0));
        send_branch(make_item(OP_UPDATE,  32'h0000_03FF, 1'b1));
        send_branch(make_item(OP_PREDICT, 32'hFFFF_FFFF, 1'b0));
        send_branch(make_item(OP_UPDATE,  32'hABCD_E3FF, 1'b0));
        send_branch(make_item(OP_PREDICT, 32'h0000_03FF, 1'b0));
        no_stall = 1'b0;
    endtask

    // back to back updates of one entry lean on forwarding, both ends saturate
    task automatic test_two_bit();
        int i;
        write_mode(MODE_TWO_BIT);
        no_stall = 1'b1;
        for (i = 0; i < 3; i++) send_branch(make_item(OP_UPDATE, 32'h0000_0123, 1'b1));
        for (i = 0; i < 4; i++) send_branch(make_item(OP_UPDATE, 32'h8000_0123, 1'b0));
        send_branch(make_item(OP_PREDICT, 32'h0000_0123, 1'b1));
        no_stall = 1'b0;
    endtask

    // history shifts on update only, index follows pc xor history
    task automatic test_gshare();
        write_mode(MODE_GSHARE);
        send_branch(make_item(OP_UPDATE,  32'h0000_0155, 1'b1));
        send_branch(make_item(OP_UPDATE,  32'h0000_0155, 1'b0));
        send_branch(make_item(OP_PREDICT, 32'h0000_0155, 1'b1));
        send_branch(make_item(OP_UPDATE,  32'hFFFF_FEAA, 1'b1));
    endtask

    // phases of mixed traffic, most of it on a few hot branches so tables train
    task automatic test_random_traffic();
        int              k;
        int              n;
        int              r;
        logic [PC_W-1:0] pc;
        logic            op;
        logic            tk;
        logic [MODE_W-1:0] m;
        for (k = 0; k < RANDOM_PHASES; k++) begin
            case (k)
                0:       m = MODE_GSHARE;
                1:       m = MODE_TWO_BIT;
                2:       m = MODE_ONE_BIT;
                3:       m = MODE_TAKEN;
                4:       m = MODE_GSHARE;
                5:       m = MODE_NOT_TAKEN;
                6:       m = MODE_SPARE_HI;
                7:       m = MODE_TWO_BIT;
                default: m = MODE_ONE_BIT;
            endcase
            write_mode(m);
            for (n = 0; n < HOT_PCS; n++) hot_pc[n] = $urandom;
            // one phase runs with no idling at all
            no_stall = (k == 4);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    pc = (r[0]) ? 32'hFFFF_FFFF : 32'h0000_0000;
                else if (r < 70)
                    pc = hot_pc[$urandom_range(0, HOT_PCS - 1)];
                else if (r < 85)
                    // alias of a hot branch, same low bits
                    pc = {PC_W'($urandom)} & ~PC_W'(LOCAL_DEPTH - 1)
                         | (hot_pc[$urandom_range(0, HOT_PCS - 1)] & PC_W'(LOCAL_DEPTH - 1));
                else
                    pc = $urandom;
                op = ($urandom_range(0, 99) < 65) ? OP_UPDATE : OP_PREDICT;
                tk = ($urandom_range(0, 99) < 70);
                send_branch(make_item(op, pc, tk));
            end
        end
        no_stall = 1'b0;
    endtask

    // result side: ready drops for random stretches unless told otherwise
    initial begin
        int n;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!no_stall && $urandom_range(0, 3) == 0) begin
                i_out_ready = 1'b0;
                n = idle_length() + 1;
                repeat (n) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
        end
    end

    // compare every result beat with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            if (expected_results.size() == 0) begin
                if (mismatch_count + stray_count < REPORT_MAX)
                    $display("unexpected result beat: %p", o_out_data);
                stray_count++;
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (o_out_data.prediction    !== want.prediction    ||
                    o_out_data.counter_state !== want.counter_state ||
                    o_out_data.state_valid   !== want.state_valid   ||
                    o_out_data.table_index   !== want.table_index   ||
                    o_out_data.history_out   !== want.history_out) begin
                    if (mismatch_count + stray_count < REPORT_MAX) begin
                        $display("mismatch %0d want pred %0b ctr %0d vld %0b idx %0h hist %0h",
                                 results_checked, want.prediction, want.counter_state,
                                 want.state_valid, want.table_index, want.history_out);
                        $display("  got pred %0b ctr %0d vld %0b idx %0h hist %0h",
                                 o_out_data.prediction, o_out_data.counter_state,
                                 o_out_data.state_valid, o_out_data.table_index,
                                 o_out_data.history_out);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid === 1'b1 && o_in_ready === 1'b1) ||
            (o_out_valid === 1'b1 && i_out_ready === 1'b1) ||
            (i_cfg_valid === 1'b1 && o_cfg_ready === 1'b1)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", idle_cycles);
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        int leftover;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_in_data       = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = '0;
        no_stall        = 1'b0;
        beats_sent      = 0;
        updates_sent    = 0;
        mode_writes     = 0;
        results_checked = 0;
        mismatch_count  = 0;
        stray_count     = 0;
        idle_cycles     = 0;
        clear_shadow();

        // synchronous reset held, then released at a falling edge
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_static_modes();
        test_one_bit();
        test_two_bit();
        test_gshare();
        test_random_traffic();

        // drain, then settle to catch anything stray
        i_in_valid = 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        leftover = expected_results.size();

        $display("sent %0d item beats (%0d updates) over %0d mode writes, all eight mode codes",
                 beats_sent, updates_sent, mode_writes);
        $display("checked %0d result beats: %0d mismatches, %0d unexpected, %0d missing",
                 results_checked, mismatch_count, stray_count, leftover);
        if (mismatch_count == 0 && stray_count == 0 && leftover == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
